@@ src/svalloc_pkg.sv @@
// Shared types and constants for the voice allocator.
`timescale 1ns / 1ps

package svalloc_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VOICE_W    = 4;
    localparam int NOTE_W     = 7;
    localparam int NUM_NOTES  = 128;
    localparam int VEL_W      = 7;
    localparam int LEVEL_W    = 16;
    localparam int AGE_W      = 32;
    localparam int APB_AW     = 3;

    localparam logic [LEVEL_W-1:0] TOL_RESET = 16'd7;

    // Register select, taken from paddr[2]
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_TOL    = 1'b1;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_RETRIG  = 2'd1,
        ACT_FADE    = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_SUSTAIN = 2'd1,
        PH_RELEASE = 2'd2,
        PH_FADE    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_ALL_OFF  = 2'd2,
        MODE_REPORT   = 2'd3
    } mode_t;

    // Steal classes, lower is stolen first
    localparam logic [1:0] CLS_RELEASING = 2'd0;
    localparam logic [1:0] CLS_PEDAL     = 2'd1;
    localparam logic [1:0] CLS_HELD      = 2'd2;
    localparam logic [1:0] CLS_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]         cls;
        logic [LEVEL_W-1:0] level;
        logic [AGE_W-1:0]   age;
    } cand_t;

    typedef struct packed {
        action_t            action;
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic               last;
    } cmd_t;

endpackage

@@ src/svalloc_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module svalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/svalloc_steal_cmp.sv @@
// Steal candidate compare: class, then level within tolerance, then age.
`timescale 1ns / 1ps

module svalloc_steal_cmp
    import svalloc_pkg::*;
(
    input  cand_t              cand,
    input  cand_t              best,
    input  logic [LEVEL_W-1:0] tol,
    output logic               better
);

    logic [LEVEL_W:0]   lvl_plus_tol;
    logic [LEVEL_W-1:0] diff;
    logic               lower;
    logic               tied_older;

    assign lvl_plus_tol = {1'b0, cand.level} + {1'b0, tol};
    assign diff = (cand.level >= best.level) ? (cand.level - best.level)
                                             : (best.level - cand.level);
    // clearly lower level wins; near-equal level falls back to age
    assign lower      = lvl_plus_tol < {1'b0, best.level};
    assign tied_older = (diff < tol) && (cand.age > best.age);

    assign better = (cand.cls < best.cls)
                 || ((cand.cls == best.cls) && (lower || tied_older));

endmodule

@@ src/synth_voice_allocator_core.sv @@
// Voice allocator: note-on/off to voice commands, with voice stealing.
// A voice report updates the voice tables when taken; note-off reads the note map, then S_NOFF issues the release;
// a retrigger issues from S_MAP; a new voice scans to the lowest idle voice, then S_START; a steal scans every
// voice, then S_VICTIM, S_FADE and S_START; all-notes-off walks the voices at one per cycle while cmd_stall is low.
// Throughput is one item at a time: items are taken only in S_IDLE, and the single compare unit scans the voices
// one per cycle. Reset clears the control state, voice tables and note map valid bits, not the note map RAM.
`timescale 1ns / 1ps

module synth_voice_allocator_core
    import svalloc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         mode,
    input  logic [NOTE_W-1:0]  note,
    input  logic [VEL_W-1:0]   velocity,
    input  logic [VOICE_W-1:0] voice_index,
    input  logic               report_active,
    input  logic [1:0]         report_phase,
    input  logic               report_sustained,
    input  logic [LEVEL_W-1:0] report_level,
    input  logic [AGE_W-1:0]   report_age,
    output logic               cmd_valid,
    input  logic               cmd_stall,
    output logic [1:0]         action,
    output logic [VOICE_W-1:0] voice,
    output logic [NOTE_W-1:0]  cmd_note,
    output logic [VEL_W-1:0]   cmd_velocity,
    output logic               last
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MAP    = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_VICTIM = 8'b0000_1000,
        S_FADE   = 8'b0001_0000,
        S_START  = 8'b0010_0000,
        S_NOFF   = 8'b0100_0000,
        S_ANO    = 8'b1000_0000
    } state_t;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);

    state_t state_reg, state_next;

    logic               enable_reg;
    logic [LEVEL_W-1:0] tol_reg;

    logic [NUM_NOTES-1:0]  map_valid_reg, map_valid_next;
    logic [NUM_VOICES-1:0] active_reg, active_next;
    logic [NUM_VOICES-1:0] pedal_reg, pedal_next;
    phase_t                phase_reg [NUM_VOICES];
    phase_t                phase_next [NUM_VOICES];
    logic [LEVEL_W-1:0]    level_reg [NUM_VOICES];
    logic [LEVEL_W-1:0]    level_next [NUM_VOICES];
    logic [AGE_W-1:0]      age_reg [NUM_VOICES];
    logic [AGE_W-1:0]      age_next [NUM_VOICES];
    logic [NOTE_W-1:0]     vnote_reg [NUM_VOICES];
    logic [NOTE_W-1:0]     vnote_next [NUM_VOICES];

    logic [NOTE_W-1:0]  note_reg, note_next;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic [NOTE_W-1:0]  ram_addr_reg, ram_addr_next;
    logic [VOICE_W-1:0] target_reg, target_next;
    logic [VOICE_W-1:0] idx_reg, idx_next;
    cand_t              best_reg, best_next;
    logic [VOICE_W-1:0] best_idx_reg, best_idx_next;

    cmd_t out_reg;
    logic out_valid_reg;

    logic               item_fire;
    logic               cfg_fire;
    logic               slot_free;
    logic               emit_fire;
    cmd_t               emit_cmd;
    logic [VOICE_W-1:0] rd_idx;
    logic               rd_active;
    logic [NOTE_W-1:0]  rd_note;
    cand_t              rd_cand;
    logic               better;
    logic               none_above;
    logic [NUM_VOICES-1:0] low_mask;

    logic               ram_we;
    logic [VOICE_W-1:0] ram_wdata;
    logic [NOTE_W-1:0]  ram_raddr;
    logic [VOICE_W-1:0] ram_rdata;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign cfg_fire = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_ENABLE: prdata = {31'b0, enable_reg};
            REG_TOL:    prdata = {16'b0, tol_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            tol_reg    <= TOL_RESET;
        end
        else if (cfg_fire)
        begin
            case (paddr[2])
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_TOL:    tol_reg    <= pwdata[LEVEL_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- shared voice read and compare ----------------
    assign item_stall = (state_reg != S_IDLE);
    assign item_fire  = item_valid && !item_stall;
    assign slot_free  = !out_valid_reg || !cmd_stall;

    always_comb
    begin
        case (state_reg)
            S_SCAN, S_ANO:  rd_idx = idx_reg;
            S_MAP, S_NOFF:  rd_idx = ram_rdata;
            S_VICTIM:       rd_idx = best_idx_reg;
            default:        rd_idx = target_reg;
        endcase
    end

    assign rd_active = active_reg[rd_idx];
    assign rd_note   = vnote_reg[rd_idx];

    always_comb
    begin
        rd_cand.level = level_reg[rd_idx];
        rd_cand.age   = age_reg[rd_idx];
        if (phase_reg[rd_idx] == PH_RELEASE || phase_reg[rd_idx] == PH_FADE)
        begin
            rd_cand.cls = CLS_RELEASING;
        end
        else if (pedal_reg[rd_idx])
        begin
            rd_cand.cls = CLS_PEDAL;
        end
        else
        begin
            rd_cand.cls = CLS_HELD;
        end
    end

    svalloc_steal_cmp u_cmp (
        .cand   (rd_cand),
        .best   (best_reg),
        .tol    (tol_reg),
        .better (better)
    );

    // bits at or below idx_reg; wraps to all ones at the top voice
    assign low_mask   = (NUM_VOICES'(2) << idx_reg) - NUM_VOICES'(1);
    assign none_above = ~|(active_reg & ~low_mask);

    // ---------------- note map ----------------
    always_comb
    begin
        case (state_reg)
            S_IDLE:   ram_raddr = note;
            S_VICTIM: ram_raddr = rd_note;
            default:  ram_raddr = ram_addr_reg;
        endcase
    end

    svalloc_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (NUM_NOTES)
    ) u_note_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (note_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        map_valid_next = map_valid_reg;
        active_next    = active_reg;
        pedal_next     = pedal_reg;
        phase_next     = phase_reg;
        level_next     = level_reg;
        age_next       = age_reg;
        vnote_next     = vnote_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        ram_addr_next  = ram_addr_reg;
        target_next    = target_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        ram_we         = 1'b0;
        ram_wdata      = target_reg;
        emit_fire      = 1'b0;
        emit_cmd       = '{action: ACT_RELEASE, voice: '0, note: '0, vel: '0, last: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    note_next     = note;
                    vel_next      = velocity;
                    ram_addr_next = note;
                    case (mode_t'(mode))
                        MODE_NOTE_ON:
                        begin
                            if (enable_reg)
                            begin
                                state_next = S_MAP;
                            end
                        end
                        MODE_NOTE_OFF:
                        begin
                            if (map_valid_reg[note])
                            begin
                                state_next = S_NOFF;
                            end
                        end
                        MODE_ALL_OFF:
                        begin
                            map_valid_next = '0;
                            idx_next       = '0;
                            if (|active_reg)
                            begin
                                state_next = S_ANO;
                            end
                        end
                        MODE_REPORT:
                        begin
                            if ({1'b0, voice_index} < (VOICE_W + 1)'(NUM_VOICES))
                            begin
                                active_next[voice_index] = report_active;
                                phase_next[voice_index]  = phase_t'(report_phase);
                                pedal_next[voice_index]  = report_sustained;
                                level_next[voice_index]  = report_level;
                                age_next[voice_index]    = report_age;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_MAP:
            begin
                if (map_valid_reg[note_reg])
                begin
                    if (slot_free)
                    begin
                        active_next[ram_rdata] = 1'b1;
                        phase_next[ram_rdata]  = PH_ATTACK;
                        pedal_next[ram_rdata]  = 1'b0;
                        level_next[ram_rdata]  = '0;
                        age_next[ram_rdata]    = '0;
                        vnote_next[ram_rdata]  = note_reg;
                        ram_we                 = 1'b1;
                        ram_wdata              = ram_rdata;
                        emit_fire              = 1'b1;
                        emit_cmd = '{action: ACT_RETRIG, voice: ram_rdata,
                                     note: note_reg, vel: vel_reg, last: 1'b1};
                        state_next             = S_IDLE;
                    end
                end
                else
                begin
                    idx_next      = '0;
                    best_next     = '{cls: CLS_NONE, level: '0, age: '0};
                    best_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // first idle voice ends the scan; otherwise track the steal victim
                if (!rd_active)
                begin
                    target_next = idx_reg;
                    state_next  = S_START;
                end
                else
                begin
                    if (better)
                    begin
                        best_next     = rd_cand;
                        best_idx_next = idx_reg;
                    end
                    if (idx_reg == LAST_VOICE)
                    begin
                        state_next = S_VICTIM;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_VICTIM:
            begin
                target_next   = best_idx_reg;
                ram_addr_next = rd_note;
                state_next    = S_FADE;
            end

            S_FADE:
            begin
                if (slot_free)
                begin
                    // drop the victim's old note mapping if it still points here
                    if (map_valid_reg[ram_addr_reg] && ram_rdata == target_reg)
                    begin
                        map_valid_next[ram_addr_reg] = 1'b0;
                    end
                    phase_next[target_reg] = PH_FADE;
                    emit_fire  = 1'b1;
                    emit_cmd   = '{action: ACT_FADE, voice: target_reg,
                                   note: '0, vel: '0, last: 1'b0};
                    state_next = S_START;
                end
            end

            S_START:
            begin
                if (slot_free)
                begin
                    active_next[target_reg] = 1'b1;
                    phase_next[target_reg]  = PH_ATTACK;
                    pedal_next[target_reg]  = 1'b0;
                    level_next[target_reg]  = '0;
                    age_next[target_reg]    = '0;
                    vnote_next[target_reg]  = note_reg;
                    map_valid_next[note_reg] = 1'b1;
                    ram_we                  = 1'b1;
                    ram_wdata               = target_reg;
                    emit_fire               = 1'b1;
                    emit_cmd = '{action: ACT_START, voice: target_reg,
                                 note: note_reg, vel: vel_reg, last: 1'b1};
                    state_next              = S_IDLE;
                end
            end

            S_NOFF:
            begin
                if (slot_free)
                begin
                    if (rd_active)
                    begin
                        phase_next[ram_rdata] = PH_RELEASE;
                    end
                    map_valid_next[note_reg] = 1'b0;
                    emit_fire  = 1'b1;
                    emit_cmd   = '{action: ACT_RELEASE, voice: ram_rdata,
                                   note: '0, vel: '0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            S_ANO:
            begin
                if (rd_active)
                begin
                    if (slot_free)
                    begin
                        phase_next[idx_reg] = PH_RELEASE;
                        emit_fire = 1'b1;
                        emit_cmd  = '{action: ACT_RELEASE, voice: idx_reg,
                                      note: '0, vel: '0, last: none_above};
                        if (none_above)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_valid_reg <= '0;
            active_reg    <= '0;
            pedal_reg     <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                phase_reg[i] <= PH_ATTACK;
                level_reg[i] <= '0;
                age_reg[i]   <= '0;
                vnote_reg[i] <= '0;
            end
            idx_reg       <= '0;
            target_reg    <= '0;
            best_idx_reg  <= '0;
            best_reg      <= '{cls: CLS_NONE, level: '0, age: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_valid_reg <= map_valid_next;
            active_reg    <= active_next;
            pedal_reg     <= pedal_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            age_reg       <= age_next;
            vnote_reg     <= vnote_next;
            idx_reg       <= idx_next;
            target_reg    <= target_next;
            best_idx_reg  <= best_idx_next;
            best_reg      <= best_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!cmd_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg     <= note_next;
        vel_reg      <= vel_next;
        ram_addr_reg <= ram_addr_next;
        if (emit_fire)
        begin
            out_reg <= emit_cmd;
        end
    end

    assign cmd_valid    = out_valid_reg;
    assign action       = out_reg.action;
    assign voice        = out_reg.voice;
    assign cmd_note     = out_reg.note;
    assign cmd_velocity = out_reg.vel;
    assign last         = out_reg.last;

    // ---------------- assertions ----------------
    a_fade_then_start: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_cmd.action == ACT_FADE)
        |=> (state_reg == S_START && target_reg == $past(emit_cmd.voice)))
        else $error("fade transfer not followed by start on the same voice");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_cmd.last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final command");

    a_start_maps_note: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_cmd.action == ACT_START) |=> map_valid_reg[$past(note_reg)])
        else $error("started note left unmapped");

    a_scan_class_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && $past(state_reg) == S_SCAN)
        |-> (best_reg.cls <= $past(best_reg.cls)))
        else $error("steal class grew during scan");

    a_ano_release_active: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && state_reg == S_ANO) |-> active_reg[emit_cmd.voice])
        else $error("all-notes-off released an idle voice");

endmodule
